// ===== rtl/estc_pkg.sv =====
// Package for the epoch-seconds to calendar converter: state type, constants and month table.
`timescale 1ns / 1ps
`default_nettype none

package estc_pkg;

    // Sequencer states of the converter.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAYS,
        ST_DAY_REM,
        ST_HOURS,
        ST_HOUR_REM,
        ST_MINUTES,
        ST_MIN_REM,
        ST_YEARS,
        ST_MONTHS
    } estc_state_t;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned BASE_YEAR     = 1970;

    // Reciprocals for the constant divisions. Each divisor is split into a power
    // of two, removed by a shift, and an odd part, divided by multiplying with
    // ceil(2^k / odd) and keeping the product from bit k upwards:
    //   86400 = 2^7 * 675, k = 35, exact for a 25-bit dividend;
    //   3600  = 2^4 * 225, k = 21, exact for a 13-bit dividend;
    //   60    = 2^2 * 15,  k = 14, exact for a 10-bit dividend.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [25:0] HOUR_RECIP = 26'd9321;
    localparam logic [25:0] MIN_RECIP  = 26'd1093;

    // Residues of the base year, so that the leap rule needs no divider.
    localparam logic [6:0] BASE_MOD100 = 7'(BASE_YEAR % 100);
    localparam logic [8:0] BASE_MOD400 = 9'(BASE_YEAR % 400);

    localparam logic [3:0] MONTH_DEC = 4'd11;

    // Length of a month in days; month index 0 is January.
    function automatic logic [4:0] days_in_month(input logic [3:0] mi, input logic leap);
        logic [4:0] n;
        begin
            unique case (mi)
                4'd1:                      n = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
                default:                   n = 5'd31;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Top level of the converter from Unix epoch seconds to a UTC Gregorian date and time of day.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is started by raising start while busy is low; epoch_seconds is
// sampled at that edge. busy then stays high through the fixed arithmetic, the
// year compares and the month compares. The longest case is December 2105, with
// Y = 135 whole years since 1970 and M = 11 whole months in the last year. The
// fixed arithmetic finds the whole days, then the hour and then the minute by
// multiplying with a reciprocal, each followed by a step that multiplies back
// and subtracts to leave the remainder; the year and month loops then remove one
// year or one month per cycle on the shared subtractor, whose borrow doubles as
// the compare. The result appears on year, month, day, hour, minute and second
// with done high for exactly one cycle, the same cycle in which busy falls. The
// result ports are also used as working registers during a conversion, so they
// are only valid while done is high. The receiver cannot stall the block, so it
// must take the result in that cycle; a new transaction may be started in that
// same cycle.
module epoch_seconds_to_calendar
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] epoch_seconds,
    output logic             done,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second
);

    estc_pkg::estc_state_t state_reg, state_next;

    // Working registers of the sequencer.
    logic [31:0] rem_reg, rem_next;      // seconds not yet placed in days, hours or minutes
    logic [15:0] days_reg, days_next;    // whole days left to place in the calendar
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  mi_reg, mi_next;        // month index, 0 is January
    logic        done_reg, done_next;

    // Result registers.
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;

    // The shared subtractor, whose borrow doubles as the compare.
    logic [31:0] alu_a, alu_b;
    logic [32:0] alu_diff;
    logic        alu_borrow;

    // The shared multiplier for the reciprocal divisions and the multiply-backs.
    logic [25:0] mul_a, mul_b;
    logic [51:0] mul_p;

    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  month_len;

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[32];
    assign mul_p      = {26'd0, mul_a} * {26'd0, mul_b};

    // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
    assign leap      = ((year_reg[1:0] == 2'd0) && (mod100_reg != 7'd0)) ||
                       (mod400_reg == 9'd0);
    assign year_len  = leap ? 9'd366 : 9'd365;
    assign month_len = estc_pkg::days_in_month(mi_reg, leap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= estc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        days_reg   <= days_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        mi_reg     <= mi_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        days_next   = days_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        mi_next     = mi_reg;
        done_next   = 1'b0;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        alu_a       = rem_reg;
        alu_b       = 32'd0;
        mul_a       = 26'd0;
        mul_b       = 26'd0;

        unique case (state_reg)
            estc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = epoch_seconds;
                    state_next = estc_pkg::ST_DAYS;
                end
            end

            // Whole days: drop the factor 2^7 of 86400, then divide by 675.
            estc_pkg::ST_DAYS:
            begin
                mul_a      = {1'b0, rem_reg[31:7]};
                mul_b      = estc_pkg::DAY_RECIP;
                days_next  = mul_p[50:35];
                state_next = estc_pkg::ST_DAY_REM;
            end

            // Seconds within the day.
            estc_pkg::ST_DAY_REM:
            begin
                mul_a      = {10'd0, days_reg};
                mul_b      = 26'(estc_pkg::SECS_PER_DAY);
                alu_b      = mul_p[31:0];
                rem_next   = alu_diff[31:0];
                state_next = estc_pkg::ST_HOURS;
            end

            // Hour: drop the factor 2^4 of 3600, then divide by 225.
            estc_pkg::ST_HOURS:
            begin
                mul_a      = {13'd0, rem_reg[16:4]};
                mul_b      = estc_pkg::HOUR_RECIP;
                hour_next  = mul_p[25:21];
                state_next = estc_pkg::ST_HOUR_REM;
            end

            // Seconds within the hour.
            estc_pkg::ST_HOUR_REM:
            begin
                mul_a      = {21'd0, hour_reg};
                mul_b      = 26'(estc_pkg::SECS_PER_HOUR);
                alu_b      = mul_p[31:0];
                rem_next   = alu_diff[31:0];
                state_next = estc_pkg::ST_MINUTES;
            end

            // Minute: drop the factor 2^2 of 60, then divide by 15.
            estc_pkg::ST_MINUTES:
            begin
                mul_a       = {16'd0, rem_reg[11:2]};
                mul_b       = estc_pkg::MIN_RECIP;
                minute_next = mul_p[19:14];
                state_next  = estc_pkg::ST_MIN_REM;
            end

            // Seconds within the minute, and the start of the year loop.
            estc_pkg::ST_MIN_REM:
            begin
                mul_a       = {20'd0, minute_reg};
                mul_b       = 26'(estc_pkg::SECS_PER_MIN);
                alu_b       = mul_p[31:0];
                second_next = alu_diff[5:0];
                year_next   = 12'(estc_pkg::BASE_YEAR);
                mod100_next = estc_pkg::BASE_MOD100;
                mod400_next = estc_pkg::BASE_MOD400;
                state_next  = estc_pkg::ST_YEARS;
            end

            // Remove one whole year per cycle while the remaining days cover it.
            estc_pkg::ST_YEARS:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = {23'd0, year_len};
                if (!alu_borrow)
                begin
                    days_next   = alu_diff[15:0];
                    year_next   = year_reg + 12'd1;
                    mod100_next = (mod100_reg == 7'd99)  ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
                else
                begin
                    mi_next    = 4'd0;
                    state_next = estc_pkg::ST_MONTHS;
                end
            end

            // Remove one whole month per cycle; December takes whatever is left.
            estc_pkg::ST_MONTHS:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = {27'd0, month_len};
                if (!alu_borrow && (mi_reg != estc_pkg::MONTH_DEC))
                begin
                    days_next = alu_diff[15:0];
                    mi_next   = mi_reg + 4'd1;
                end
                else
                begin
                    month_next = mi_reg + 4'd1;
                    day_next   = days_reg[4:0] + 5'd1;
                    done_next  = 1'b1;
                    state_next = estc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = estc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != estc_pkg::ST_IDLE);
    assign done   = done_reg;
    assign year   = year_reg;
    assign month  = month_reg;
    assign day    = day_reg;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

`default_nettype wire
